// ===== sv/rfm_pkg.sv =====
// Package for the reciprocal frequency meter with seven-segment readout.
// Holds the widths, reset values, register indexes, states and the digit table.
// No dependencies.
package rfm_pkg;

	localparam int TICK_COUNT_BITS = 32;
	localparam int EDGE_BITS = 8;
	localparam int RATE_BITS = 27;
	localparam int FREQ_BITS = 24;
	localparam int PROD_BITS = EDGE_BITS + RATE_BITS;
	localparam int SEG_BITS = 7;
	localparam int DIGIT_BITS = 4;
	localparam int STEP_BITS = $clog2(PROD_BITS + 1);
	localparam int CFG_INDEX_BITS = 2;
	localparam int TEN = 10;
	localparam int TENS_MAX = 9;

	localparam logic [FREQ_BITS-1:0] FREQ_MAX = '1;
	localparam logic [EDGE_BITS-1:0] EDGES_RESET = 8'd10;
	localparam logic [RATE_BITS-1:0] RATE_RESET = 27'd12048193;
	localparam logic [SEG_BITS-1:0] SEG_ZERO = 7'b0000001;
	localparam logic [SEG_BITS-1:0] SEG_BLANK = 7'b1111111;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_EDGES_PER_MEASURE = 2'd0,
		REG_TICK_RATE_HZ = 2'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_FREQ,
		ST_DIV_TEN,
		ST_FINISH
	} meter_state_t;

	// Active-low segments a..g in bits 6..0.
	function automatic logic [SEG_BITS-1:0] digit_seg(input logic [DIGIT_BITS-1:0] digit);
		logic [SEG_BITS-1:0] seg;
		unique case (digit)
			4'd0: seg = 7'b0000001;
			4'd1: seg = 7'b1001111;
			4'd2: seg = 7'b0010010;
			4'd3: seg = 7'b0000110;
			4'd4: seg = 7'b1001100;
			4'd5: seg = 7'b0100100;
			4'd6: seg = 7'b0100000;
			4'd7: seg = 7'b0001111;
			4'd8: seg = 7'b0000000;
			4'd9: seg = 7'b0000100;
			default: seg = SEG_BLANK;
		endcase
		return seg;
	endfunction

endpackage

// ===== sv/reciprocal_frequency_meter_7seg_top.sv =====
// Reciprocal frequency meter: counts reference ticks and signal edges, divides,
// and drives a two-digit seven-segment readout. Depends on rfm_pkg.
//
// Channel   Handshake                  Payload
// sample    sample_valid/sample_stall  tick, edge_req
// result    result_valid/result_stall  frequency_hz, seg_tens, seg_units, over_range
// cfg       cfg_valid/cfg_ready        cfg_index, cfg_data
//
// A sample that does not finish a measurement is accepted without a stall.
// A measuring sample keeps sample_stall high through the states ST_DIV_FREQ,
// ST_DIV_TEN and ST_FINISH, taking one restoring divider step per cycle, first
// for the frequency and then again for its tens and units digits.
// The finish state waits while a previous result is still stalled on the output.
// Reset is asynchronous and active low; it clears all control state.
module reciprocal_frequency_meter_7seg_top import rfm_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  logic                      tick,
	input  logic                      edge_req,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [FREQ_BITS-1:0]      frequency_hz,
	output logic [SEG_BITS-1:0]       seg_tens,
	output logic [SEG_BITS-1:0]       seg_units,
	output logic                      over_range,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [RATE_BITS-1:0]      cfg_data
);

	meter_state_t state_q, state_d;

	logic [EDGE_BITS-1:0]       epm_q;
	logic [RATE_BITS-1:0]       rate_q;
	logic [TICK_COUNT_BITS-1:0] tick_cnt_q, tick_next;
	logic [EDGE_BITS-1:0]       edge_cnt_q, edge_next;
	logic                       sample_acc, measure, result_load;

	logic [PROD_BITS-1:0]       quo_q, quo_step;
	logic [TICK_COUNT_BITS-1:0] rem_q, rem_step, dvs_q;
	logic [STEP_BITS-1:0]       step_cnt_q;
	logic [TICK_COUNT_BITS:0]   trial;
	logic [TICK_COUNT_BITS+1:0] diff;
	logic                       step_ge, step_last;
	logic [FREQ_BITS-1:0]       freq_sat, freq_q, tens;
	logic [SEG_BITS-1:0]        held_q, seg_t_now;
	logic                       over_now;

	assign sample_acc = sample_valid && (state_q == ST_IDLE);
	assign tick_next = (tick && (tick_cnt_q != '1)) ? tick_cnt_q + 1'b1 : tick_cnt_q;
	assign edge_next = edge_cnt_q + 1'b1;
	assign measure = edge_req && !((edge_next < epm_q) && (edge_next != '0));
	assign step_last = (step_cnt_q == STEP_BITS'(1));

	// Shared restoring divider step. A zero divisor yields an all-ones quotient.
	assign trial = {rem_q, quo_q[PROD_BITS-1]};
	assign diff = {1'b0, trial} - {2'b00, dvs_q};
	assign step_ge = !diff[TICK_COUNT_BITS+1];
	assign rem_step = step_ge ? diff[TICK_COUNT_BITS-1:0] : trial[TICK_COUNT_BITS-1:0];
	assign quo_step = {quo_q[PROD_BITS-2:0], step_ge};
	assign freq_sat = (|quo_step[PROD_BITS-1:FREQ_BITS]) ? FREQ_MAX : quo_step[FREQ_BITS-1:0];

	assign tens = quo_q[FREQ_BITS-1:0];
	assign over_now = tens > FREQ_BITS'(TENS_MAX);
	assign seg_t_now = over_now ? held_q : digit_seg(tens[DIGIT_BITS-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		sample_stall = 1'b1;
		cfg_ready = 1'b0;
		result_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				cfg_ready = 1'b1;
				if (sample_acc && measure) begin
					state_d = ST_DIV_FREQ;
				end
			end
			ST_DIV_FREQ: begin
				if (step_last) begin
					state_d = ST_DIV_TEN;
				end
			end
			ST_DIV_TEN: begin
				if (step_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!result_valid || !result_stall) begin
					result_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epm_q <= EDGES_RESET;
			rate_q <= RATE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_EDGES_PER_MEASURE: epm_q <= cfg_data[EDGE_BITS-1:0];
				REG_TICK_RATE_HZ: rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_cnt_q <= '0;
			edge_cnt_q <= '0;
		end else if (sample_acc) begin
			if (measure) begin
				tick_cnt_q <= '0;
				edge_cnt_q <= '0;
			end else begin
				tick_cnt_q <= tick_next;
				if (edge_req) begin
					edge_cnt_q <= edge_next;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_cnt_q <= '0;
		end else if (sample_acc && measure) begin
			step_cnt_q <= STEP_BITS'(PROD_BITS);
		end else if (state_q == ST_DIV_FREQ && step_last) begin
			step_cnt_q <= STEP_BITS'(FREQ_BITS);
		end else if (state_q == ST_DIV_FREQ || state_q == ST_DIV_TEN) begin
			step_cnt_q <= step_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_acc && measure) begin
			quo_q <= PROD_BITS'(rate_q) * PROD_BITS'(epm_q);
			rem_q <= '0;
			dvs_q <= tick_next;
		end else if (state_q == ST_DIV_FREQ && step_last) begin
			freq_q <= freq_sat;
			quo_q <= PROD_BITS'(freq_sat) << (PROD_BITS - FREQ_BITS);
			rem_q <= '0;
			dvs_q <= TICK_COUNT_BITS'(TEN);
		end else if (state_q == ST_DIV_FREQ || state_q == ST_DIV_TEN) begin
			quo_q <= quo_step;
			rem_q <= rem_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
			held_q <= SEG_ZERO;
		end else begin
			if (result_load) begin
				result_valid <= 1'b1;
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
			if (result_load && !over_now) begin
				held_q <= seg_t_now;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			frequency_hz <= freq_q;
			seg_tens <= seg_t_now;
			seg_units <= digit_seg(rem_q[DIGIT_BITS-1:0]);
			over_range <= over_now;
		end
	end

	a_edge_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		edge_cnt_q != '1)
		else $error("edge counter reached its all-ones value");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_FINISH))
		else $error("result appeared without a finished measurement");

	a_over_range_matches: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (over_range == (frequency_hz >= FREQ_BITS'(TEN * (TENS_MAX + 1)))))
		else $error("over_range disagrees with the frequency");

	a_held_tracks_tens: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !over_range) |-> (seg_tens == held_q))
		else $error("held tens pattern not updated");

endmodule
